// ----- sv/ctt_pkg.sv -----
package ctt_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        KIND_END       = 4'd0,
        KIND_NUMBER    = 4'd1,
        KIND_STRING    = 4'd2,
        KIND_NAME      = 4'd3,
        KIND_EQUALS    = 4'd4,
        KIND_COLON     = 4'd5,
        KIND_COMMA     = 4'd6,
        KIND_BANG      = 4'd7,
        KIND_NODEBEGIN = 4'd8,
        KIND_NODEEND   = 4'd9,
        KIND_VECBEGIN  = 4'd10,
        KIND_VECEND    = 4'd11,
        KIND_INVALID   = 4'd12
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_COMMENT    = 4'd2,
        MODE_NUMBER     = 4'd3,
        MODE_STR_START  = 4'd4,
        MODE_STR        = 4'd5,
        MODE_ESC_START  = 4'd6,
        MODE_ESC        = 4'd7,
        MODE_NAME       = 4'd8,
        MODE_NODE_START = 4'd9,
        MODE_NODE       = 4'd10,
        MODE_INVALID    = 4'd11
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic        has_char;
        logic [7:0]  char_out;
        logic        first;
        logic        last;
        logic [31:0] end_offset;
        logic        slash_error;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } entry_t;

endpackage

// ----- sv/config_text_tokenizer.sv -----
// Streaming tokenizer for a bracketed configuration text: one text byte per
// transaction in, token results out (at most one text byte per result,
// first/last marks, closing results with the byte offset, lone-slash error
// flags, end token on a zero byte). The front end classifies a byte and updates
// the scan mode and the saturating byte counter together, so it takes one byte
// every cycle while the result queue (QueueDepth entries) has room. A byte
// yields zero, one or two results; the output register sends one result per
// cycle while m_ready is high; the second result of a byte that closes a token
// and opens or ends another waits in a pending register.
module config_text_tokenizer #(
    parameter int unsigned QueueDepth = ctt_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic        m_has_char,
    output logic [7:0]  m_char_out,
    output logic        m_token_first,
    output logic        m_token_last,
    output logic [31:0] m_end_offset,
    output logic        m_slash_error
);

    logic             q_push;
    logic             q_ready;
    ctt_pkg::entry_t  q_entry;
    logic             q_pop;
    logic             head_valid;
    ctt_pkg::entry_t  head_entry;
    ctt_pkg::result_t m_result;

    ctt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .q_push      (q_push),
        .q_entry     (q_entry),
        .q_ready     (q_ready)
    );

    ctt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ctt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_token_kind  = m_result.kind;
    assign m_has_char    = m_result.has_char;
    assign m_char_out    = m_result.char_out;
    assign m_token_first = m_result.first;
    assign m_token_last  = m_result.last;
    assign m_end_offset  = m_result.end_offset;
    assign m_slash_error = m_result.slash_error;

    a_end_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == ctt_pkg::KIND_END) |->
            m_token_first && m_token_last && !m_has_char)
        else $error("end token without both marks");

    a_slash_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_slash_error |->
            (m_token_kind == ctt_pkg::KIND_INVALID) && !m_has_char &&
            !m_token_first && !m_token_last)
        else $error("malformed slash error result");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_char |-> (m_char_out == 8'd0))
        else $error("char_out set without has_char");

    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_token_last && !m_slash_error |-> (m_end_offset == 32'd0))
        else $error("offset on a result that does not end a token");

endmodule

// ----- sv/ctt_front.sv -----
module ctt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_text_byte,
    output logic              q_push,
    output ctt_pkg::entry_t   q_entry,
    input  logic              q_ready
);

    ctt_pkg::mode_t   mode_reg, mode_next;
    logic [31:0]      count_reg, count_next;
    logic [31:0]      cnt_inc;
    logic             accept;
    logic [7:0]       b;

    ctt_pkg::mode_t   idle_mode;
    logic [31:0]      idle_count;
    logic             idle_valid;
    ctt_pkg::result_t idle_res;

    logic             pre_valid;
    ctt_pkg::result_t pre_res;
    logic             use_idle;
    logic             first;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ctt_pkg::CH_ZERO) && (c <= ctt_pkg::CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= ctt_pkg::CH_LO_A) && (c <= ctt_pkg::CH_LO_Z)) ||
               ((c >= ctt_pkg::CH_UP_A) && (c <= ctt_pkg::CH_UP_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == ctt_pkg::CH_SPACE) || (c == ctt_pkg::CH_TAB) ||
               (c == ctt_pkg::CH_CR) || (c == ctt_pkg::CH_LF);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == ctt_pkg::CH_MINUS) ||
               (c == ctt_pkg::CH_UNDER);
    endfunction

    function automatic logic is_number_char(input logic [7:0] c);
        return is_digit(c) || (c == ctt_pkg::CH_DOT) || (c == ctt_pkg::CH_LO_E) ||
               (c == ctt_pkg::CH_UP_E) || (c == ctt_pkg::CH_PLUS) ||
               (c == ctt_pkg::CH_MINUS);
    endfunction

    function automatic logic ends_invalid(input logic [7:0] c);
        return (c == ctt_pkg::CH_NUL) || is_space(c) || (c == ctt_pkg::CH_LBRACK) ||
               (c == ctt_pkg::CH_RBRACK) || (c == ctt_pkg::CH_EQUALS) ||
               (c == ctt_pkg::CH_COLON) || (c == ctt_pkg::CH_COMMA);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c == ctt_pkg::CH_EQUALS) || (c == ctt_pkg::CH_COLON) ||
               (c == ctt_pkg::CH_COMMA) || (c == ctt_pkg::CH_BANG) ||
               (c == ctt_pkg::CH_RBRACK) || (c == ctt_pkg::CH_LBRACE) ||
               (c == ctt_pkg::CH_RBRACE);
    endfunction

    function automatic ctt_pkg::kind_t single_kind(input logic [7:0] c);
        ctt_pkg::kind_t k;
        case (c)
            ctt_pkg::CH_EQUALS: k = ctt_pkg::KIND_EQUALS;
            ctt_pkg::CH_COLON:  k = ctt_pkg::KIND_COLON;
            ctt_pkg::CH_COMMA:  k = ctt_pkg::KIND_COMMA;
            ctt_pkg::CH_BANG:   k = ctt_pkg::KIND_BANG;
            ctt_pkg::CH_RBRACK: k = ctt_pkg::KIND_NODEEND;
            ctt_pkg::CH_LBRACE: k = ctt_pkg::KIND_VECBEGIN;
            ctt_pkg::CH_RBRACE: k = ctt_pkg::KIND_VECEND;
            default:            k = ctt_pkg::KIND_INVALID;
        endcase
        return k;
    endfunction

    function automatic ctt_pkg::result_t text_res(input ctt_pkg::kind_t k,
                                                  input logic [7:0] c, input logic f);
        ctt_pkg::result_t r;
        r = '0;
        r.kind     = k;
        r.has_char = 1'b1;
        r.char_out = c;
        r.first    = f;
        return r;
    endfunction

    function automatic ctt_pkg::result_t close_res(input ctt_pkg::kind_t k, input logic f,
                                                   input logic [31:0] off);
        ctt_pkg::result_t r;
        r = '0;
        r.kind       = k;
        r.first      = f;
        r.last       = 1'b1;
        r.end_offset = off;
        return r;
    endfunction

    function automatic ctt_pkg::result_t error_res(input logic [31:0] off);
        ctt_pkg::result_t r;
        r = '0;
        r.kind        = ctt_pkg::KIND_INVALID;
        r.end_offset  = off;
        r.slash_error = 1'b1;
        return r;
    endfunction

    assign b       = s_text_byte;
    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign cnt_inc = (count_reg == ctt_pkg::COUNT_MAX) ? count_reg : count_reg + 32'd1;
    assign first   = (mode_reg == ctt_pkg::MODE_NODE_START) ||
                     (mode_reg == ctt_pkg::MODE_STR_START) ||
                     (mode_reg == ctt_pkg::MODE_ESC_START);

    always_comb begin
        idle_mode  = ctt_pkg::MODE_IDLE;
        idle_count = cnt_inc;
        idle_valid = 1'b0;
        idle_res   = '0;
        if (b == ctt_pkg::CH_NUL) begin
            idle_count = '0;
            idle_valid = 1'b1;
            idle_res   = close_res(ctt_pkg::KIND_END, 1'b1, count_reg);
        end else if (is_space(b)) begin
            idle_mode = ctt_pkg::MODE_IDLE;
        end else if (b == ctt_pkg::CH_SLASH) begin
            idle_mode = ctt_pkg::MODE_SLASH;
        end else if (is_digit(b)) begin
            idle_mode  = ctt_pkg::MODE_NUMBER;
            idle_valid = 1'b1;
            idle_res   = text_res(ctt_pkg::KIND_NUMBER, b, 1'b1);
        end else if (b == ctt_pkg::CH_QUOTE) begin
            idle_mode = ctt_pkg::MODE_STR_START;
        end else if (is_letter(b)) begin
            idle_mode  = ctt_pkg::MODE_NAME;
            idle_valid = 1'b1;
            idle_res   = text_res(ctt_pkg::KIND_NAME, b, 1'b1);
        end else if (b == ctt_pkg::CH_LBRACK) begin
            idle_mode = ctt_pkg::MODE_NODE_START;
        end else if (is_single(b)) begin
            idle_valid = 1'b1;
            idle_res   = text_res(single_kind(b), b, 1'b1);
            idle_res.last       = 1'b1;
            idle_res.end_offset = cnt_inc;
        end else begin
            idle_mode  = ctt_pkg::MODE_INVALID;
            idle_valid = 1'b1;
            idle_res   = text_res(ctt_pkg::KIND_INVALID, b, 1'b1);
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (accept) begin
            mode_next  = idle_mode;
            count_next = idle_count;
            case (mode_reg)
                ctt_pkg::MODE_SLASH: begin
                    if (b == ctt_pkg::CH_SLASH) begin
                        mode_next  = ctt_pkg::MODE_COMMENT;
                        count_next = cnt_inc;
                    end else if (b != ctt_pkg::CH_NUL) begin
                        mode_next  = ctt_pkg::MODE_IDLE;
                        count_next = cnt_inc;
                    end
                end
                ctt_pkg::MODE_COMMENT: begin
                    if (b != ctt_pkg::CH_NUL) begin
                        count_next = cnt_inc;
                        mode_next  = (b == ctt_pkg::CH_LF) ? ctt_pkg::MODE_IDLE
                                                           : ctt_pkg::MODE_COMMENT;
                    end
                end
                ctt_pkg::MODE_NUMBER: begin
                    if (is_number_char(b)) begin
                        mode_next  = ctt_pkg::MODE_NUMBER;
                        count_next = cnt_inc;
                    end
                end
                ctt_pkg::MODE_NAME: begin
                    if (is_name_char(b)) begin
                        mode_next  = ctt_pkg::MODE_NAME;
                        count_next = cnt_inc;
                    end
                end
                ctt_pkg::MODE_NODE_START, ctt_pkg::MODE_NODE: begin
                    if (is_name_char(b)) begin
                        mode_next  = ctt_pkg::MODE_NODE;
                        count_next = cnt_inc;
                    end
                end
                ctt_pkg::MODE_INVALID: begin
                    if (!ends_invalid(b)) begin
                        mode_next  = ctt_pkg::MODE_INVALID;
                        count_next = cnt_inc;
                    end
                end
                ctt_pkg::MODE_STR_START, ctt_pkg::MODE_STR: begin
                    if (b != ctt_pkg::CH_NUL) begin
                        count_next = cnt_inc;
                        if (b == ctt_pkg::CH_QUOTE) begin
                            mode_next = ctt_pkg::MODE_IDLE;
                        end else if (b == ctt_pkg::CH_BSLASH) begin
                            mode_next = first ? ctt_pkg::MODE_ESC_START : ctt_pkg::MODE_ESC;
                        end else begin
                            mode_next = ctt_pkg::MODE_STR;
                        end
                    end
                end
                ctt_pkg::MODE_ESC_START, ctt_pkg::MODE_ESC: begin
                    if (b != ctt_pkg::CH_NUL) begin
                        mode_next  = ctt_pkg::MODE_STR;
                        count_next = cnt_inc;
                    end
                end
                default: begin
                    mode_next  = idle_mode;
                    count_next = idle_count;
                end
            endcase
        end
    end

    always_comb begin
        pre_valid = 1'b0;
        pre_res   = '0;
        use_idle  = 1'b0;
        case (mode_reg)
            ctt_pkg::MODE_SLASH: begin
                if (b == ctt_pkg::CH_NUL) begin
                    pre_valid = 1'b1;
                    pre_res   = error_res(count_reg);
                    use_idle  = 1'b1;
                end else if (b != ctt_pkg::CH_SLASH) begin
                    pre_valid = 1'b1;
                    pre_res   = error_res(cnt_inc);
                end
            end
            ctt_pkg::MODE_COMMENT: begin
                use_idle = (b == ctt_pkg::CH_NUL);
            end
            ctt_pkg::MODE_NUMBER: begin
                pre_valid = 1'b1;
                if (is_number_char(b)) begin
                    pre_res = text_res(ctt_pkg::KIND_NUMBER, b, 1'b0);
                end else begin
                    pre_res  = close_res(ctt_pkg::KIND_NUMBER, 1'b0, count_reg);
                    use_idle = 1'b1;
                end
            end
            ctt_pkg::MODE_NAME: begin
                pre_valid = 1'b1;
                if (is_name_char(b)) begin
                    pre_res = text_res(ctt_pkg::KIND_NAME, b, 1'b0);
                end else begin
                    pre_res  = close_res(ctt_pkg::KIND_NAME, 1'b0, count_reg);
                    use_idle = 1'b1;
                end
            end
            ctt_pkg::MODE_NODE_START, ctt_pkg::MODE_NODE: begin
                pre_valid = 1'b1;
                if (is_name_char(b)) begin
                    pre_res = text_res(ctt_pkg::KIND_NODEBEGIN, b, first);
                end else begin
                    pre_res  = close_res(ctt_pkg::KIND_NODEBEGIN, first, count_reg);
                    use_idle = 1'b1;
                end
            end
            ctt_pkg::MODE_INVALID: begin
                pre_valid = 1'b1;
                if (ends_invalid(b)) begin
                    pre_res  = close_res(ctt_pkg::KIND_INVALID, 1'b0, count_reg);
                    use_idle = 1'b1;
                end else begin
                    pre_res = text_res(ctt_pkg::KIND_INVALID, b, 1'b0);
                end
            end
            ctt_pkg::MODE_STR_START, ctt_pkg::MODE_STR: begin
                if (b == ctt_pkg::CH_NUL) begin
                    pre_valid = 1'b1;
                    pre_res   = close_res(ctt_pkg::KIND_STRING, first, count_reg);
                    use_idle  = 1'b1;
                end else if (b == ctt_pkg::CH_QUOTE) begin
                    pre_valid = 1'b1;
                    pre_res   = close_res(ctt_pkg::KIND_STRING, first, cnt_inc);
                end else if (b != ctt_pkg::CH_BSLASH) begin
                    pre_valid = 1'b1;
                    pre_res   = text_res(ctt_pkg::KIND_STRING, b, first);
                end
            end
            ctt_pkg::MODE_ESC_START, ctt_pkg::MODE_ESC: begin
                pre_valid = 1'b1;
                if (b == ctt_pkg::CH_NUL) begin
                    pre_res  = close_res(ctt_pkg::KIND_STRING, first, count_reg);
                    use_idle = 1'b1;
                end else begin
                    pre_res = text_res(ctt_pkg::KIND_STRING, b, first);
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase
    end

    always_comb begin
        q_entry = '0;
        if (pre_valid) begin
            q_entry.res0 = pre_res;
            q_entry.res1 = idle_res;
            q_entry.two  = use_idle && idle_valid;
        end else begin
            q_entry.res0 = idle_res;
        end
        q_push = accept && (pre_valid || (use_idle && idle_valid));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ctt_pkg::MODE_IDLE;
            count_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/ctt_queue.sv -----
module ctt_queue #(
    parameter int unsigned Depth = ctt_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ctt_pkg::entry_t push_entry,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output ctt_pkg::entry_t head_entry
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    ctt_pkg::entry_t  slots [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != FullCnt);
    assign head_valid = (fill_reg != '0);
    assign head_entry = slots[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- sv/ctt_back.sv -----
module ctt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  ctt_pkg::entry_t  head_entry,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output ctt_pkg::result_t m_result
);

    logic             out_valid_reg, out_valid_next;
    ctt_pkg::result_t out_res_reg, out_res_next;
    logic             pend_valid_reg, pend_valid_next;
    ctt_pkg::result_t pend_res_reg, pend_res_next;
    logic             load;

    assign load     = !out_valid_reg || m_ready;
    assign pop      = load && !pend_valid_reg && head_valid;
    assign m_valid  = out_valid_reg;
    assign m_result = out_res_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (load) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = pend_res_reg;
                pend_valid_next = 1'b0;
            end else if (head_valid) begin
                out_valid_next  = 1'b1;
                out_res_next    = head_entry.res0;
                pend_valid_next = head_entry.two;
                pend_res_next   = head_entry.res1;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

// ----- dv/config_text_tokenizer_test.sv -----
`timescale 1ns / 1ps

module config_text_tokenizer_test;
    import ctt_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 20;

    class token_board;
        mode_t       mode;
        logic [31:0] count;
        result_t     awaited_tokens[$];
        int unsigned errors;

        function new();
            mode = MODE_IDLE;
            count = '0;
            errors = 0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
        endfunction

        function bit is_name_char(logic [7:0] c);
            return is_letter(c) || is_digit(c) || c == CH_MINUS || c == CH_UNDER;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
        endfunction

        function bit is_number_char(logic [7:0] c);
            return is_digit(c) || c == CH_DOT || c == CH_LO_E || c == CH_UP_E
                || c == CH_PLUS || c == CH_MINUS;
        endfunction

        function void bump();
            if (count != COUNT_MAX) begin
                count++;
            end
        endfunction

        function void push(kind_t k, logic has, logic [7:0] c, logic f, logic l,
                           logic [31:0] off, logic err);
            result_t r;
            r.kind = k;
            r.has_char = has;
            r.char_out = has ? c : 8'h00;
            r.first = f;
            r.last = l;
            r.end_offset = off;
            r.slash_error = err;
            awaited_tokens.push_back(r);
        endfunction

        function void add_text(kind_t k, logic [7:0] c, logic f);
            push(k, 1'b1, c, f, 1'b0, '0, 1'b0);
        endfunction

        function void close_token(kind_t k, logic f);
            push(k, 1'b0, 8'h00, f, 1'b1, count, 1'b0);
        endfunction

        function void between_tokens(logic [7:0] b);
            mode = MODE_IDLE;
            if (b == CH_NUL) begin
                push(KIND_END, 1'b0, 8'h00, 1'b1, 1'b1, count, 1'b0);
                count = '0;
                return;
            end
            bump();
            if (is_space(b)) begin
                return;
            end
            if (b == CH_SLASH) begin
                mode = MODE_SLASH;
            end else if (is_digit(b)) begin
                mode = MODE_NUMBER;
                add_text(KIND_NUMBER, b, 1'b1);
            end else if (b == CH_QUOTE) begin
                mode = MODE_STR_START;
            end else if (is_letter(b)) begin
                mode = MODE_NAME;
                add_text(KIND_NAME, b, 1'b1);
            end else if (b == CH_LBRACK) begin
                mode = MODE_NODE_START;
            end else begin
                case (b)
                    CH_EQUALS: push(KIND_EQUALS, 1'b1, b, 1'b1, 1'b1, count, 1'b0);
                    CH_COLON: push(KIND_COLON, 1'b1, b, 1'b1, 1'b1, count, 1'b0);
                    CH_COMMA: push(KIND_COMMA, 1'b1, b, 1'b1, 1'b1, count, 1'b0);
                    CH_BANG: push(KIND_BANG, 1'b1, b, 1'b1, 1'b1, count, 1'b0);
                    CH_RBRACK: push(KIND_NODEEND, 1'b1, b, 1'b1, 1'b1, count, 1'b0);
                    CH_LBRACE: push(KIND_VECBEGIN, 1'b1, b, 1'b1, 1'b1, count, 1'b0);
                    CH_RBRACE: push(KIND_VECEND, 1'b1, b, 1'b1, 1'b1, count, 1'b0);
                    default: begin
                        mode = MODE_INVALID;
                        add_text(KIND_INVALID, b, 1'b1);
                    end
                endcase
            end
        endfunction

        function void take_byte(logic [7:0] b);
            logic f;
            case (mode)
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        bump();
                        mode = MODE_COMMENT;
                    end else if (b == CH_NUL) begin
                        push(KIND_INVALID, 1'b0, 8'h00, 1'b0, 1'b0, count, 1'b1);
                        between_tokens(b);
                    end else begin
                        bump();
                        mode = MODE_IDLE;
                        push(KIND_INVALID, 1'b0, 8'h00, 1'b0, 1'b0, count, 1'b1);
                    end
                end
                MODE_COMMENT: begin
                    if (b == CH_NUL) begin
                        between_tokens(b);
                    end else begin
                        bump();
                        if (b == CH_LF) begin
                            mode = MODE_IDLE;
                        end
                    end
                end
                MODE_NUMBER: begin
                    if (is_number_char(b)) begin
                        bump();
                        add_text(KIND_NUMBER, b, 1'b0);
                    end else begin
                        close_token(KIND_NUMBER, 1'b0);
                        between_tokens(b);
                    end
                end
                MODE_NAME: begin
                    if (is_name_char(b)) begin
                        bump();
                        add_text(KIND_NAME, b, 1'b0);
                    end else begin
                        close_token(KIND_NAME, 1'b0);
                        between_tokens(b);
                    end
                end
                MODE_NODE_START, MODE_NODE: begin
                    f = (mode == MODE_NODE_START);
                    if (is_name_char(b)) begin
                        bump();
                        mode = MODE_NODE;
                        add_text(KIND_NODEBEGIN, b, f);
                    end else begin
                        close_token(KIND_NODEBEGIN, f);
                        between_tokens(b);
                    end
                end
                MODE_INVALID: begin
                    if (b == CH_NUL || is_space(b) || b == CH_LBRACK || b == CH_RBRACK
                        || b == CH_EQUALS || b == CH_COLON || b == CH_COMMA) begin
                        close_token(KIND_INVALID, 1'b0);
                        between_tokens(b);
                    end else begin
                        bump();
                        add_text(KIND_INVALID, b, 1'b0);
                    end
                end
                MODE_STR_START, MODE_STR: begin
                    f = (mode == MODE_STR_START);
                    if (b == CH_NUL) begin
                        close_token(KIND_STRING, f);
                        between_tokens(b);
                    end else begin
                        bump();
                        if (b == CH_QUOTE) begin
                            mode = MODE_IDLE;
                            close_token(KIND_STRING, f);
                        end else if (b == CH_BSLASH) begin
                            mode = f ? MODE_ESC_START : MODE_ESC;
                        end else begin
                            mode = MODE_STR;
                            add_text(KIND_STRING, b, f);
                        end
                    end
                end
                MODE_ESC_START, MODE_ESC: begin
                    f = (mode == MODE_ESC_START);
                    if (b == CH_NUL) begin
                        close_token(KIND_STRING, f);
                        between_tokens(b);
                    end else begin
                        bump();
                        mode = MODE_STR;
                        add_text(KIND_STRING, b, f);
                    end
                end
                default: between_tokens(b);
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_token(result_t got);
            result_t want;
            if (awaited_tokens.size() == 0) begin
                $display("%0t: unexpected result, actual kind %0d char %0h last %0b",
                         $time, got.kind, got.char_out, got.last);
                errors++;
                return;
            end
            want = awaited_tokens.pop_front();
            compare_field("token_kind", want.kind, got.kind);
            compare_field("has_char", want.has_char, got.has_char);
            compare_field("char_out", want.char_out, got.char_out);
            compare_field("token_first", want.first, got.first);
            compare_field("token_last", want.last, got.last);
            compare_field("end_offset", want.end_offset, got.end_offset);
            compare_field("slash_error", want.slash_error, got.slash_error);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic        m_has_char;
    logic [7:0]  m_char_out;
    logic        m_token_first;
    logic        m_token_last;
    logic [31:0] m_end_offset;
    logic        m_slash_error;

    token_board  board = new();
    logic [7:0]  feed[$];
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    config_text_tokenizer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_kind (m_token_kind),
        .m_has_char   (m_has_char),
        .m_char_out   (m_char_out),
        .m_token_first(m_token_first),
        .m_token_last (m_token_last),
        .m_end_offset (m_end_offset),
        .m_slash_error(m_slash_error)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind = kind_t'(m_token_kind);
            got.has_char = m_has_char;
            got.char_out = m_char_out;
            got.first = m_token_first;
            got.last = m_token_last;
            got.end_offset = m_end_offset;
            got.slash_error = m_slash_error;
            board.check_token(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("config_text_tokenizer_test: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 5))
            0: return CH_UP_A + 8'($urandom_range(0, 25));
            1: return CH_ZERO + 8'($urandom_range(0, 9));
            2: return CH_MINUS;
            3: return CH_UNDER;
            default: return CH_LO_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] pick_number_char();
        case ($urandom_range(0, 6))
            0: return CH_DOT;
            1: return CH_LO_E;
            2: return CH_UP_E;
            3: return CH_PLUS;
            4: return CH_MINUS;
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic void add_fragment();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0: feed.push_back(CH_TAB);
                    1: feed.push_back(CH_CR);
                    2: feed.push_back(CH_LF);
                    default: feed.push_back(CH_SPACE);
                endcase
            end
        end else if (pick < 28) begin
            feed.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 4)) feed.push_back(pick_number_char());
        end else if (pick < 41) begin
            feed.push_back(CH_LO_A + 8'($urandom_range(0, 25)));
            repeat ($urandom_range(0, 4)) feed.push_back(pick_name_char());
        end else if (pick < 51) begin
            feed.push_back(CH_LBRACK);
            repeat ($urandom_range(0, 3)) feed.push_back(pick_name_char());
            if ($urandom_range(0, 3) != 0) begin
                feed.push_back(CH_RBRACK);
            end
        end else if (pick < 63) begin
            feed.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        feed.push_back(CH_BSLASH);
                        feed.push_back(8'($urandom_range(1, 255)));
                    end
                    2: feed.push_back(8'($urandom_range(1, 255)));
                    default: feed.push_back(pick_name_char());
                endcase
            end
            if ($urandom_range(0, 9) != 0) begin
                feed.push_back(CH_QUOTE);
            end
        end else if (pick < 75) begin
            case ($urandom_range(0, 6))
                0: feed.push_back(CH_EQUALS);
                1: feed.push_back(CH_COLON);
                2: feed.push_back(CH_COMMA);
                3: feed.push_back(CH_BANG);
                4: feed.push_back(CH_RBRACK);
                5: feed.push_back(CH_LBRACE);
                default: feed.push_back(CH_RBRACE);
            endcase
        end else if (pick < 81) begin
            feed.push_back(CH_SLASH);
            feed.push_back(CH_SLASH);
            repeat ($urandom_range(0, 5)) feed.push_back(pick_name_char());
            feed.push_back(CH_LF);
        end else if (pick < 85) begin
            feed.push_back(CH_SLASH);
            feed.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 91) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: feed.push_back(CH_PLUS);
                    1: feed.push_back(CH_DOT);
                    default: feed.push_back(8'($urandom_range(128, 255)));
                endcase
            end
        end else if (pick < 96) begin
            feed.push_back(8'($urandom_range(0, 255)));
        end else begin
            feed.push_back(CH_NUL);
        end
    endfunction

    task automatic push_text(input string s);
        foreach (s[i]) feed.push_back(s[i]);
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_text_byte = b;
        do @(posedge aclk); while (!s_ready);
        board.take_byte(b);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned n_bytes);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        while (feed.size() < n_bytes) add_fragment();
        while (feed.size() != 0) send_byte(feed.pop_front());
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        push_text("[x]a=1e+5,\"\\\"\"\"\":!{}[ /x");
        feed.push_back(8'hFF);
        feed.push_back(8'h80);
        feed.push_back(CH_NUL);
        feed.push_back(CH_SLASH);
        feed.push_back(CH_NUL);
        feed.push_back(CH_QUOTE);
        feed.push_back(CH_BSLASH);
        feed.push_back(CH_NUL);
        feed.push_back(CH_SLASH);
        feed.push_back(CH_SLASH);
        feed.push_back(CH_NUL);
        run_phase(0, 0, 0);

        hold_request = 1'b1;
        run_phase(0, 0, 120);
        run_phase(0, 0, 300);
        run_phase(80, 0, 300);
        run_phase(0, 80, 300);
        run_phase(21, 21, 300);

        feed.push_back(CH_NUL);
        run_phase(0, 0, 0);
        @(negedge aclk);
        s_valid = 1'b0;
        receiver_stall_pct = 0;

        while (board.awaited_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("config_text_tokenizer_test: PASS");
        end else begin
            $display("config_text_tokenizer_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ctt_pkg.sv
sv/ctt_front.sv
sv/ctt_queue.sv
sv/ctt_back.sv
sv/config_text_tokenizer.sv
dv/config_text_tokenizer_test.sv
